FILE: sv/espt_pkg.sv
// Package for the ESP SPI pairing table: beat types, status codes, states.
// No dependencies; used by espt_cell and esp_spi_pairing_table_unit.
package espt_pkg;

   localparam logic [1:0] OP_TRACK = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [2:0] ST_LEARNED = 3'd0;
   localparam logic [2:0] ST_ORIG    = 3'd1;
   localparam logic [2:0] ST_REPLY   = 3'd2;
   localparam logic [2:0] ST_PAIRED  = 3'd3;
   localparam logic [2:0] ST_NOMATCH = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;
   localparam logic [2:0] ST_TICK    = 3'd6;

   // APB byte address of the lifetime register
   localparam logic [2:0] ADDR_LIFETIME = 3'd0;

   localparam logic [15:0] LIFETIME_RESET = 16'd300;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] spi;
      logic [31:0] packet_src_ip;
      logic [31:0] packet_dst_ip;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_src_spi;
      logic [31:0] out_dst_spi;
      logic [31:0] out_src_ip;
      logic [31:0] out_dst_ip;
      logic        accept;
   } rsp_type;

   // search token walking down the cell chain
   typedef struct packed {
      logic [31:0] key;
      logic        found;
      logic        reply;
      logic        free_found;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [31:0] src_spi;
      logic [31:0] dst_spi;
   } tok_type;

   // update broadcast to all cells
   typedef struct packed {
      logic        tick;
      logic [15:0] lifetime;
      logic        upd_en;
      logic        upd_set;
      logic [31:0] upd_dst_spi;
      logic        add_en;
      logic [31:0] add_src_ip;
      logic [31:0] add_dst_ip;
      logic [31:0] add_src_spi;
   } wr_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EVAL
   } state_type;

endpackage

FILE: sv/espt_cell.sv
// One table slot of the ESP pairing table plus one stage of the search chain.
// Depends on espt_pkg.
module espt_cell #(
   parameter int IDX_W   = 4,
   parameter int CELL_ID = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  espt_pkg::tok_type  tok_i,
   input  logic [IDX_W-1:0]   fidx_i,
   input  logic [IDX_W-1:0]   free_i,
   output espt_pkg::tok_type  tok_o,
   output logic [IDX_W-1:0]   fidx_o,
   output logic [IDX_W-1:0]   free_o,
   input  espt_pkg::wr_type   wr,
   input  logic [IDX_W-1:0]   upd_idx,
   input  logic [IDX_W-1:0]   add_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

   logic        valid_ff;
   logic [31:0] src_ip_ff, dst_ip_ff, src_spi_ff, dst_spi_ff;
   logic [15:0] ttl_ff;

   espt_pkg::tok_type tok_ff, tok_in;
   logic [IDX_W-1:0]  fidx_ff, fidx_in, free_ff, free_in;

   always_comb begin
      tok_in  = tok_i;
      fidx_in = fidx_i;
      free_in = free_i;
      if (!tok_i.found && valid_ff &&
          (src_spi_ff == tok_i.key || dst_spi_ff == tok_i.key)) begin
         tok_in.found   = 1'b1;
         tok_in.reply   = (src_spi_ff != tok_i.key);
         tok_in.src_ip  = src_ip_ff;
         tok_in.dst_ip  = dst_ip_ff;
         tok_in.src_spi = src_spi_ff;
         tok_in.dst_spi = dst_spi_ff;
         fidx_in        = MY_IDX;
      end
      if (!tok_i.free_found && !valid_ff) begin
         tok_in.free_found = 1'b1;
         free_in           = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      fidx_ff <= fidx_in;
      free_ff <= free_in;
   end

   assign tok_o  = tok_ff;
   assign fidx_o = fidx_ff;
   assign free_o = free_ff;

   // slot storage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.tick) begin
         if (valid_ff && ttl_ff <= 16'd1) valid_ff <= 1'b0;
      end else if (wr.add_en && add_idx == MY_IDX) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.tick) begin
         if (valid_ff && ttl_ff > 16'd1) ttl_ff <= ttl_ff - 16'd1;
      end else if (wr.add_en && add_idx == MY_IDX) begin
         src_ip_ff  <= wr.add_src_ip;
         dst_ip_ff  <= wr.add_dst_ip;
         src_spi_ff <= wr.add_src_spi;
         dst_spi_ff <= 32'd0;
         ttl_ff     <= wr.lifetime;
      end else if (wr.upd_en && upd_idx == MY_IDX) begin
         if (wr.upd_set) dst_spi_ff <= wr.upd_dst_spi;
         ttl_ff <= wr.lifetime;
      end
   end

endmodule

FILE: sv/esp_spi_pairing_table_unit.sv
// Top level of the ESP SPI pairing table: controller, APB register, cell chain.
// Depends on espt_pkg and espt_cell.
//
// Tick and undefined ops go from start straight to evaluate; inbound query
// and outbound track scan the chain first, and track scans it a second time
// when the pending SPI must be looked up; the token walks one slot per cycle.
// Throughput: one beat at a time; the next start is taken in the rsp_valid
// cycle. rsp_valid is a one-cycle strobe, the receiver cannot stall.
// Synchronous active-high reset clears all slots, pending SPI, lifetime=300.
module esp_spi_pairing_table_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  espt_pkg::req_type req_data,
   output logic              rsp_valid,
   output espt_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(TABLE_ENTRIES - 1);

   // ---- configuration register
   logic [15:0] lifetime_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == espt_pkg::ADDR_LIFETIME) ? {16'd0, lifetime_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= espt_pkg::LIFETIME_RESET;
      end else if (psel && penable && pwrite && paddr == espt_pkg::ADDR_LIFETIME) begin
         lifetime_ff <= pwdata[15:0];
      end
   end

   // ---- request latch and control state
   espt_pkg::state_type state_ff, state_in;
   espt_pkg::req_type   req_ff;
   logic [31:0]         key_ff, pending_ff, pending_in;
   logic                second_ff;
   logic [IDX_W-1:0]    cnt_ff;
   logic                rsp_valid_ff;
   espt_pkg::rsp_type   rsp_ff, rsp_in;

   // decision made in the evaluate cycle
   logic              need2;
   espt_pkg::wr_type  wr;
   logic [IDX_W-1:0]  upd_idx, add_idx;

   // ---- cell chain
   espt_pkg::tok_type tok   [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]  fidx  [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]  free  [TABLE_ENTRIES+1];

   always_comb begin
      tok[0]     = '0;
      tok[0].key = key_ff;
      fidx[0]    = '0;
      free[0]    = '0;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      espt_cell #(.IDX_W(IDX_W), .CELL_ID(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_i   (tok[i]),
         .fidx_i  (fidx[i]),
         .free_i  (free[i]),
         .tok_o   (tok[i+1]),
         .fidx_o  (fidx[i+1]),
         .free_o  (free[i+1]),
         .wr      (wr),
         .upd_idx (upd_idx),
         .add_idx (add_idx)
      );
   end

   espt_pkg::tok_type res;
   assign res = tok[TABLE_ENTRIES];

   // ---- evaluate: outputs, slot writes, pending update
   always_comb begin
      need2      = 1'b0;
      pending_in = pending_ff;
      rsp_in     = '0;
      rsp_in.status = espt_pkg::ST_NOMATCH;
      wr          = '0;
      wr.lifetime = lifetime_ff;
      upd_idx     = fidx[TABLE_ENTRIES];
      add_idx     = free[TABLE_ENTRIES];
      if (state_ff == espt_pkg::S_EVAL) begin
         unique case (req_ff.op)
            espt_pkg::OP_TRACK: begin
               rsp_in.accept = 1'b1;
               if (!second_ff && res.found) begin
                  wr.upd_en = 1'b1;
                  if (pending_ff == req_ff.spi && res.src_ip != req_ff.packet_src_ip) begin
                     // our own pending SPI seen from another host: pair it
                     wr.upd_set         = 1'b1;
                     wr.upd_dst_spi     = req_ff.spi;
                     pending_in         = 32'd0;
                     rsp_in.out_dst_spi = pending_ff;
                     rsp_in.status      = espt_pkg::ST_PAIRED;
                  end else if (!res.reply) begin
                     rsp_in.out_src_spi = res.src_spi;
                     rsp_in.out_dst_spi = res.dst_spi;
                     rsp_in.status      = espt_pkg::ST_ORIG;
                  end else begin
                     rsp_in.out_src_spi = res.dst_spi;
                     rsp_in.out_dst_spi = res.src_spi;
                     rsp_in.status      = espt_pkg::ST_REPLY;
                  end
               end else if (!second_ff && pending_ff != 32'd0) begin
                  need2 = 1'b1;
               end else if (second_ff && !res.found) begin
                  rsp_in.status = espt_pkg::ST_NOMATCH;
               end else if (second_ff && res.dst_ip != req_ff.packet_dst_ip) begin
                  wr.upd_en          = 1'b1;
                  wr.upd_set         = 1'b1;
                  wr.upd_dst_spi     = req_ff.spi;
                  pending_in         = 32'd0;
                  rsp_in.out_dst_spi = pending_ff;
                  rsp_in.status      = espt_pkg::ST_PAIRED;
               end else begin
                  // learn; same-destination pending entry closes on itself
                  if (second_ff) begin
                     wr.upd_en      = 1'b1;
                     wr.upd_set     = 1'b1;
                     wr.upd_dst_spi = pending_ff;
                  end
                  pending_in         = req_ff.spi;
                  rsp_in.out_src_spi = req_ff.spi;
                  if (res.free_found) begin
                     wr.add_en      = 1'b1;
                     wr.add_src_ip  = req_ff.packet_src_ip;
                     wr.add_dst_ip  = req_ff.packet_dst_ip;
                     wr.add_src_spi = req_ff.spi;
                     rsp_in.status  = espt_pkg::ST_LEARNED;
                  end else begin
                     rsp_in.status  = espt_pkg::ST_FULL;
                  end
               end
            end
            espt_pkg::OP_QUERY: begin
               if (res.found) begin
                  wr.upd_en         = 1'b1;
                  rsp_in.out_src_ip = res.src_ip;
                  rsp_in.out_dst_ip = res.dst_ip;
                  rsp_in.accept     = 1'b1;
                  rsp_in.status     = res.reply ? espt_pkg::ST_REPLY : espt_pkg::ST_ORIG;
               end
            end
            espt_pkg::OP_TICK: begin
               wr.tick       = 1'b1;
               rsp_in.accept = 1'b1;
               rsp_in.status = espt_pkg::ST_TICK;
            end
            default: begin
               rsp_in.status = espt_pkg::ST_NOMATCH;
            end
         endcase
      end
   end

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         espt_pkg::S_IDLE: begin
            if (start) begin
               if (req_data.op == espt_pkg::OP_TRACK || req_data.op == espt_pkg::OP_QUERY)
                  state_in = espt_pkg::S_SCAN;
               else
                  state_in = espt_pkg::S_EVAL;
            end
         end
         espt_pkg::S_SCAN: begin
            if (cnt_ff == LAST_CNT) state_in = espt_pkg::S_EVAL;
         end
         espt_pkg::S_EVAL: begin
            state_in = need2 ? espt_pkg::S_SCAN : espt_pkg::S_IDLE;
         end
         default: state_in = espt_pkg::S_IDLE;
      endcase
   end

   // ---- outputs of the state machine
   always_comb begin
      busy = (state_ff != espt_pkg::S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= espt_pkg::S_IDLE;
         pending_ff   <= 32'd0;
         second_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == espt_pkg::S_EVAL) && !need2;
         if (state_ff == espt_pkg::S_EVAL) pending_ff <= pending_in;
         if (state_ff == espt_pkg::S_SCAN) cnt_ff <= cnt_ff + 1'b1;
         else                              cnt_ff <= '0;
         if (state_ff == espt_pkg::S_IDLE) second_ff <= 1'b0;
         else if (need2)                   second_ff <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == espt_pkg::S_IDLE && start) begin
         req_ff <= req_data;
         key_ff <= req_data.spi;
      end else if (need2) begin
         key_ff <= pending_ff;
      end
      if (state_ff == espt_pkg::S_EVAL) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- assertions
   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == espt_pkg::S_EVAL))
      else $error("result strobe without evaluate cycle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_second_only_track: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> req_ff.op == espt_pkg::OP_TRACK)
      else $error("second scan outside track request");

endmodule
